FILE: design/two_wheel_imu_odometry_macros.svh
// Assertion macros shared by the odometry RTL.
// Included by design files that carry concurrent checks; no dependencies.
`ifndef TWO_WHEEL_IMU_ODOMETRY_MACROS_SVH
`define TWO_WHEEL_IMU_ODOMETRY_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TWIO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twio check failed");

// Next-cycle implication, disabled in reset
`define TWIO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twio check failed");

`endif

FILE: design/twio_pkg.sv
// Shared types, constants and helper functions for the odometry block.
// No dependencies; imported by the odometry top level and the CORDIC.
package twio_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_ROTATE,
      ST_SCALE,
      ST_LOAD,
      ST_PROJECT,
      ST_SUM
   } state_type;

   localparam logic [2:0] CSR_RADIAL_SCALE     = 3'd0;
   localparam logic [2:0] CSR_TRANSVERSE_SCALE = 3'd1;
   localparam logic [2:0] CSR_WHEEL_OFFSET     = 3'd2;
   localparam logic [2:0] CSR_START_X          = 3'd3;
   localparam logic [2:0] CSR_START_Y          = 3'd4;

   localparam logic [31:0] RADIAL_SCALE_RST     = 32'd2618050;
   localparam logic [31:0] TRANSVERSE_SCALE_RST = 32'd26180;

   localparam logic [15:0] FULL_TURN    = 16'd36000;
   localparam logic [15:0] HALF_TURN    = 16'd18000;
   localparam logic [15:0] QUARTER_TURN = 16'd9000;
   localparam logic [15:0] THREE_QUARTER_TURN = 16'd27000;

   // radians per centidegree, Q46
   localparam logic signed [34:0] RAD_PER_CDEG = 35'sd12281662764;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

   localparam int MUL_W = 33;

   function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         5'd24: r = 34'sd63;
         5'd25: r = 34'sd31;
         5'd26: r = 34'sd15;
         5'd27: r = 34'sd8;
         5'd28: r = 34'sd4;
         5'd29: r = 34'sd2;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: design/twio_sermul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first.
// Depends on nothing; instanced by the odometry top level.
module twio_sermul #(
   parameter int W = 33
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [W-1:0]     mcand,
   input  logic signed [W-1:0]     mplier,
   output logic                    done,
   output logic signed [2*W-1:0]   prod
);
   localparam int CW = $clog2(W);

   logic signed [W-1:0] mcand_ff, mcand_in;
   logic signed [W+1:0] hi_ff, hi_in;
   logic [W-1:0]        lo_ff, lo_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic signed [W+1:0] addend, sum;
   logic                last;

   assign last = (cnt_ff == CW'(W - 1));

   // add or subtract the multiplicand, then shift the pair right
   always_comb begin
      addend = '0;
      if (lo_ff[0]) begin
         addend = last ? -(W+2)'(mcand_ff) : (W+2)'(mcand_ff);
      end
      sum      = hi_ff + addend;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff[W-1:0], lo_ff};

endmodule

FILE: design/twio_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on twio_pkg for the arctangent table and gain constant.
module twio_cordic
   import twio_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] angle,
   input  logic               flip,
   output logic               done,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   localparam int SW = $clog2(CORDIC_STEPS);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] xs, ys, at, xc, yc;
   logic [SW-1:0]      step_ff, step_in;
   logic               busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;

   always_comb begin
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = atan_lut(5'(step_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = angle;
         step_in = '0;
         busy_in = 1'b1;
         flip_in = flip;
      end else if (busy_ff) begin
         // rotate toward zero residual angle
         if (!z_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   // clamp to unit range, negate for the half-turn fold
   always_comb begin
      xc = (x_ff > ONE_Q30) ? ONE_Q30 : ((x_ff < -ONE_Q30) ? -ONE_Q30 : x_ff);
      yc = (y_ff > ONE_Q30) ? ONE_Q30 : ((y_ff < -ONE_Q30) ? -ONE_Q30 : y_ff);
      if (flip_ff) begin
         xc = -xc;
         yc = -yc;
      end
   end

   assign done    = done_ff;
   assign cos_out = xc[31:0];
   assign sin_out = yc[31:0];

endmodule

FILE: design/two_wheel_imu_odometry.sv
// Two-wheel odometry with IMU heading: top-level sequencer and state.
// Depends on twio_pkg, twio_cordic, twio_sermul and the macros header.
//
// One item at a time. An item goes from accept to result through an angle
// state, the CORDIC (one step per cycle), a scaling pass of four parallel
// 33-bit bit-serial multipliers, a load state, a projection pass of the same
// multipliers and a summing state. A finished result waits in the output
// register while the next item is accepted. Config writes are taken every cycle.
`include "two_wheel_imu_odometry_macros.svh"
module two_wheel_imu_odometry
   import twio_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [15:0]        req_heading,
   input  logic signed [31:0] req_radial_count,
   input  logic signed [31:0] req_transverse_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   state_type state_ff, state_in;

   logic [31:0]        rscale_ff, tscale_ff;
   logic signed [31:0] woff_ff, startx_ff, starty_ff;
   logic [31:0]        prev_rad_ff, prev_tra_ff;
   logic signed [31:0] prev_offx_ff, prev_offy_ff, track_x_ff, track_y_ff;
   logic signed [31:0] dr_ff, dt_ff;
   logic               cmd_ff, flip_ff;
   logic signed [14:0] ang_ff;
   logic signed [31:0] offx_ff, offy_ff, mr_ff, mt_ff;
   logic signed [41:0] dx_ff, dy_ff;
   logic               rsp_valid_ff;

   logic               req_beat, out_free;
   logic [15:0]        h_mod, h_rel;
   logic signed [14:0] ang_new;
   logic               flip_new;
   logic signed [49:0] zp;
   logic               cor_start, cor_done;
   logic signed [31:0] sin_v, cos_v;
   logic               mul_start;
   logic [3:0]         mul_done;
   logic signed [MUL_W-1:0]   ma [4];
   logic signed [MUL_W-1:0]   mb [4];
   logic signed [2*MUL_W-1:0] mp [4];
   logic signed [65:0] sh0, sh1, sh2, sh3, sumx, sumy;
   logic signed [41:0] nx, ny;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // fold heading into [-9000, 9000] centidegrees
   always_comb begin
      h_mod    = (req_heading >= FULL_TURN) ? req_heading - FULL_TURN : req_heading;
      flip_new = 1'b0;
      h_rel    = h_mod;
      if (h_mod > QUARTER_TURN && h_mod <= THREE_QUARTER_TURN) begin
         h_rel    = h_mod - HALF_TURN;
         flip_new = 1'b1;
      end else if (h_mod > THREE_QUARTER_TURN) begin
         h_rel = h_mod - FULL_TURN;
      end
      ang_new = h_rel[14:0];
   end

   // angle to Q2.30 radians, rounded
   assign zp        = 50'(ang_ff) * 50'(RAD_PER_CDEG) + 50'sd32768;
   assign cor_start = (state_ff == ST_ANGLE);

   twio_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (zp[49:16]),
      .flip    (flip_ff),
      .done    (cor_done),
      .sin_out (sin_v),
      .cos_out (cos_v)
   );

   // operand select: scaling pass after CORDIC, projection pass after load
   always_comb begin
      mul_start = 1'b0;
      ma[0] = MUL_W'(woff_ff);
      mb[0] = MUL_W'(cos_v);
      ma[1] = MUL_W'(woff_ff);
      mb[1] = MUL_W'(sin_v);
      ma[2] = MUL_W'(dr_ff);
      mb[2] = MUL_W'({1'b0, rscale_ff});
      ma[3] = MUL_W'(dt_ff);
      mb[3] = MUL_W'({1'b0, tscale_ff});
      if (state_ff == ST_ROTATE && cor_done) begin
         mul_start = 1'b1;
      end else if (state_ff == ST_LOAD) begin
         mul_start = 1'b1;
         ma[0] = MUL_W'(mr_ff);
         mb[0] = MUL_W'(sin_v);
         ma[1] = MUL_W'(mt_ff);
         mb[1] = MUL_W'(cos_v);
         ma[2] = MUL_W'(mr_ff);
         mb[2] = MUL_W'(cos_v);
         ma[3] = MUL_W'(mt_ff);
         mb[3] = MUL_W'(sin_v);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_mul
      twio_sermul #(.W(MUL_W)) u_mul (
         .clock  (clock),
         .reset  (reset),
         .start  (mul_start),
         .mcand  (ma[g]),
         .mplier (mb[g]),
         .done   (mul_done[g]),
         .prod   (mp[g])
      );
   end

   assign sh0  = 66'(mp[0]) >>> 30;
   assign sh1  = 66'(mp[1]) >>> 30;
   assign sh2  = 66'(mp[2]) >>> 8;
   assign sh3  = 66'(mp[3]) >>> 8;
   assign sumx = 66'(mp[0]) + 66'(mp[1]);
   assign sumy = 66'(mp[2]) - 66'(mp[3]);

   // new position: x offset change subtracted, y offset change added
   assign nx = track_x_ff + dx_ff - offx_ff + prev_offx_ff;
   assign ny = track_y_ff + dy_ff + offy_ff - prev_offy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_beat) state_in = ST_ANGLE;
         ST_ANGLE:   state_in = ST_ROTATE;
         ST_ROTATE:  if (cor_done) state_in = ST_SCALE;
         ST_SCALE:   if (mul_done[0]) state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_PROJECT;
         ST_PROJECT: if (mul_done[0]) state_in = ST_SUM;
         ST_SUM:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rscale_ff <= RADIAL_SCALE_RST;
         tscale_ff <= TRANSVERSE_SCALE_RST;
         woff_ff   <= '0;
         startx_ff <= '0;
         starty_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIAL_SCALE:     rscale_ff <= csr_data;
            CSR_TRANSVERSE_SCALE: tscale_ff <= csr_data;
            CSR_WHEEL_OFFSET:     woff_ff   <= csr_data;
            CSR_START_X:          startx_ff <= csr_data;
            CSR_START_Y:          starty_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // tracker state and output
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rad_ff  <= '0;
         prev_tra_ff  <= '0;
         prev_offx_ff <= '0;
         prev_offy_ff <= '0;
         track_x_ff   <= '0;
         track_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_beat) begin
            prev_rad_ff <= req_radial_count;
            prev_tra_ff <= req_transverse_count;
         end
         if (state_ff == ST_SUM && out_free) begin
            prev_offx_ff <= offx_ff;
            prev_offy_ff <= offy_ff;
            track_x_ff   <= cmd_ff ? startx_ff : sat32(66'(nx));
            track_y_ff   <= cmd_ff ? starty_ff : sat32(66'(ny));
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff  <= req_cmd;
         flip_ff <= flip_new;
         ang_ff  <= ang_new;
         dr_ff   <= req_radial_count - prev_rad_ff;
         dt_ff   <= req_transverse_count - prev_tra_ff;
      end
      if (state_ff == ST_SCALE && mul_done[0]) begin
         offx_ff <= sat32(sh0);
         offy_ff <= sat32(sh1);
         mr_ff   <= sat32(sh2);
         mt_ff   <= sat32(sh3);
      end
      if (state_ff == ST_PROJECT && mul_done[0]) begin
         dx_ff <= 42'(sumx >>> 30);
         dy_ff <= 42'(sumy >>> 30);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = track_x_ff;
   assign rsp_pos_y = track_y_ff;

   `TWIO_ASSERT_IMP(a_mul_lockstep, clock, reset, mul_done[0], mul_done == 4'b1111)
   `TWIO_ASSERT_IMP(a_cordic_in_rotate, clock, reset, cor_done, state_ff == ST_ROTATE)
   `TWIO_ASSERT_NXT(a_sum_posts, clock, reset, state_ff == ST_SUM && out_free,
                    rsp_valid_ff && state_ff == ST_IDLE)
   `TWIO_ASSERT_IMP(a_rsp_from_sum, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == ST_SUM)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for two_wheel_imu_odometry: drives position items,
// predicts the tracked position and compares every result beat.
// Depends on twio_pkg and the RTL in the design folder.
module testbench
   import twio_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 16;
   localparam int LATENCY = STEPS + 80;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } position_type;

   // Position predictor plus queue of expected positions
   class odometry_scoreboard;
      logic [31:0] radial_scale, transverse_scale;
      logic signed [63:0] wheel_offset, start_x, start_y;
      logic [31:0] prev_radial, prev_transverse;
      logic signed [63:0] prev_off_x, prev_off_y, track_x, track_y;
      position_type pending[$];
      int mismatches;

      function new();
         radial_scale = RADIAL_SCALE_RST;
         transverse_scale = TRANSVERSE_SCALE_RST;
         wheel_offset = 0; start_x = 0; start_y = 0;
         prev_radial = 0; prev_transverse = 0;
         prev_off_x = 0; prev_off_y = 0; track_x = 0; track_y = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_RADIAL_SCALE:     radial_scale = data;
            CSR_TRANSVERSE_SCALE: transverse_scale = data;
            CSR_WHEEL_OFFSET:     wheel_offset = $signed(data);
            CSR_START_X:          start_x = $signed(data);
            CSR_START_Y:          start_y = $signed(data);
            default: ;
         endcase
      endfunction

      function logic signed [63:0] clip32(logic signed [127:0] v);
         if (v > 128'sd2147483647) return 64'sd2147483647;
         if (v < -128'sd2147483648) return -64'sd2147483648;
         return v[63:0];
      endfunction

      function logic signed [63:0] clip_unit(logic signed [63:0] v);
         if (v > ONE_Q30) return ONE_Q30;
         if (v < -ONE_Q30) return -ONE_Q30;
         return v;
      endfunction

      // Fold heading, CORDIC rotate, unfold
      function void heading_sin_cos(logic [15:0] hdg, output logic signed [63:0] s,
                                    output logic signed [63:0] c);
         logic signed [63:0] h, a, x, y, z, xs, ys;
         logic flip;
         logic [63:0] angles[30];
         angles = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                    127, 63, 31, 15, 8, 4, 2};
         h = hdg % 36000;
         flip = 0;
         if (h > 9000 && h <= 27000) begin
            a = h - 18000; flip = 1;
         end else if (h > 27000) begin
            a = h - 36000;
         end else begin
            a = h;
         end
         z = (a * 64'sd12281662764 + 32768) >>> 16;
         x = 652032874; y = 0;
         for (int i = 0; i < STEPS && i < 30; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - $signed(angles[i]);
            end else begin
               x = x + ys; y = y - xs; z = z + $signed(angles[i]);
            end
         end
         x = clip_unit(x); y = clip_unit(y);
         if (flip) begin
            x = -x; y = -y;
         end
         s = y; c = x;
      endfunction

      function logic signed [63:0] count_meters(logic [31:0] now, logic [31:0] was,
                                                logic [31:0] scale);
         logic signed [31:0] d;
         logic signed [127:0] p;
         d = now - was;
         p = 128'(d) * $signed({96'd0, scale});
         return clip32(p >>> 8);
      endfunction

      // Note an accepted input beat
      function void note_item(logic cmd, logic [15:0] hdg, logic [31:0] rc,
                              logic [31:0] tc);
         logic signed [63:0] s, c, ox, oy, mr, mt;
         logic signed [127:0] dx, dy;
         position_type p;
         heading_sin_cos(hdg, s, c);
         ox = clip32((128'(wheel_offset) * 128'(c)) >>> 30);
         oy = clip32((128'(wheel_offset) * 128'(s)) >>> 30);
         if (cmd) begin
            track_x = start_x; track_y = start_y;
         end else begin
            mr = count_meters(rc, prev_radial, radial_scale);
            mt = count_meters(tc, prev_transverse, transverse_scale);
            dx = (128'(mr) * 128'(s) + 128'(mt) * 128'(c)) >>> 30;
            dy = (128'(mr) * 128'(c) - 128'(mt) * 128'(s)) >>> 30;
            track_x = clip32(128'(track_x) + dx - 128'(ox - prev_off_x));
            track_y = clip32(128'(track_y) + dy + 128'(oy - prev_off_y));
         end
         prev_radial = rc; prev_transverse = tc;
         prev_off_x = ox; prev_off_y = oy;
         p.pos_x = track_x[31:0]; p.pos_y = track_y[31:0];
         pending.push_back(p);
      endfunction

      // Check a result beat against the oldest expectation
      function void check_result(logic signed [31:0] px, logic signed [31:0] py);
         position_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", px, py);
            return;
         end
         e = pending.pop_front();
         if (px !== e.pos_x || py !== e.pos_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("position mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                        e.pos_x, e.pos_y, px, py);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_cmd;
   logic [15:0] req_heading;
   logic signed [31:0] req_radial_count, req_transverse_count;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   odometry_scoreboard board;
   int send_idle_pct, recv_idle_pct, hold_off;
   logic [31:0] last_rc, last_tc;

   two_wheel_imu_odometry #(.CORDIC_STEPS(STEPS)) uut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls plus long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_pos_x, rsp_pos_y);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one beat, hold it until accepted, then drop valid
   task automatic send_item(logic cmd, logic [15:0] hdg, logic [31:0] rc,
                            logic [31:0] tc);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1; req_cmd <= cmd; req_heading <= hdg;
      req_radial_count <= rc; req_transverse_count <= tc;
      do @(posedge clock); while (!req_ready);
      board.note_item(cmd, hdg, rc, tc);
      last_rc = rc; last_tc = tc;
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1; csr_index <= idx; csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Random count near the previous one, sometimes anywhere
   function automatic logic [31:0] next_count(logic [31:0] was);
      if ($urandom_range(9) == 0) return $urandom;
      return was + 32'($signed($urandom_range(4000)) - 2000);
   endfunction

   task automatic random_items(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(24) == 0)
            send_item(1, 16'($urandom_range(35999)), $urandom, $urandom);
         else
            send_item(0, ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(35999)),
                      next_count(last_rc), next_count(last_tc));
      end
   endtask

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      board = new();
      reset = 1; req_valid = 0; req_cmd = 0; req_heading = 0;
      req_radial_count = 0; req_transverse_count = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      send_idle_pct = 6; recv_idle_pct = 49; hold_off = 0;
      last_rc = 0; last_tc = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: update before start, headings at fold edges, wraps, extremes
      send_item(0, 100, 10, 200);
      drain();
      write_reg(CSR_WHEEL_OFFSET, 32'h0200_0000);
      write_reg(CSR_START_X, 32'h0100_0000);
      write_reg(CSR_START_Y, 32'hff00_0000);
      write_reg(3'd7, 32'hdead_beef);
      send_item(1, 0, 32'h7fff_fff0, 32'h8000_0010);
      send_item(0, 9000, 32'h8000_0005, 32'h7fff_fff5);
      send_item(0, 9001, 32'h8000_0105, 32'h7fff_f000);
      send_item(0, 18000, 32'h8000_0205, 32'h7fff_e000);
      send_item(0, 27000, 32'h8000_0305, 32'h7fff_d000);
      send_item(0, 27001, 32'h8000_0405, 32'h7fff_c000);
      send_item(0, 35999, 32'h8000_0505, 32'h7fff_b000);
      send_item(0, 16'hffff, 32'h8000_0605, 32'h7fff_a000);
      send_item(0, 36000, 32'h8000_0705, 32'h7fff_9000);
      send_item(0, 4500, 32'h0000_0705, 32'hffff_9000);
      send_item(0, 4500, 32'h7fff_ffff, 32'h8000_0000);
      send_item(0, 31500, 32'h8000_0000, 32'h7fff_ffff);
      drain();

      // Extreme scales drive saturation of deltas and position
      write_reg(CSR_RADIAL_SCALE, 32'hffff_ffff);
      write_reg(CSR_TRANSVERSE_SCALE, 32'hffff_ffff);
      write_reg(CSR_WHEEL_OFFSET, 32'h8000_0000);
      write_reg(CSR_START_X, 32'h7fff_ffff);
      write_reg(CSR_START_Y, 32'h8000_0000);
      send_item(1, 1234, 0, 0);
      send_item(0, 2000, 32'h4000_0000, 32'hc000_0000);
      send_item(0, 20000, 32'h8000_0000, 32'h0000_0000);
      send_item(0, 30000, 32'h0, 32'h8000_0000);
      drain();
      write_reg(CSR_RADIAL_SCALE, 32'd0);
      write_reg(CSR_TRANSVERSE_SCALE, 32'd0);
      write_reg(CSR_WHEEL_OFFSET, 32'h7fff_ffff);
      write_reg(CSR_START_X, 32'h0);
      write_reg(CSR_START_Y, 32'h0);
      send_item(0, 5000, 32'h1234, 32'h5678);
      send_item(0, 25000, 32'h4321, 32'h8765);
      drain();

      // Random phases: receiver stalls mostly, then sender, then neither
      write_reg(CSR_RADIAL_SCALE, RADIAL_SCALE_RST);
      write_reg(CSR_TRANSVERSE_SCALE, TRANSVERSE_SCALE_RST);
      write_reg(CSR_WHEEL_OFFSET, 32'h0040_0000);
      write_reg(CSR_START_X, 32'h0123_4567);
      write_reg(CSR_START_Y, 32'hfedc_ba98);
      hold_off = 600;
      random_items(200);
      drain();

      write_reg(CSR_RADIAL_SCALE, $urandom);
      write_reg(CSR_TRANSVERSE_SCALE, $urandom_range(1000000));
      write_reg(CSR_WHEEL_OFFSET, $urandom);
      write_reg(CSR_START_X, $urandom);
      write_reg(CSR_START_Y, $urandom);
      send_idle_pct = 49; recv_idle_pct = 6;
      random_items(200);
      drain();

      write_reg(CSR_RADIAL_SCALE, $urandom_range(8000000));
      write_reg(CSR_WHEEL_OFFSET, $urandom_range(50000000));
      send_idle_pct = 0; recv_idle_pct = 0;
      random_items(200);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
